// File: sv/wfsa_pkg.sv
// ----------------------------------------------------------------------------
// Worst-fit segment allocator package
// Shared constants, the segment record, the controller states and the structs
// that pass between the controller, the scan unit and the top level.
// ----------------------------------------------------------------------------
package wfsa_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int MAX_REQUESTS = 4096;
    localparam int ADDRESS_BITS = 16;

    localparam int CELL_W     = 17;
    localparam int SEG_IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int LINK_W     = SEG_IDX_W + 1;
    localparam int REQ_IDX_W  = $clog2(MAX_REQUESTS);
    localparam int REQ_CNT_W  = REQ_IDX_W + 1;
    localparam int NUM_W      = 13;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [LINK_W-1:0]    SEG_NONE  = LINK_W'(MAX_SEGMENTS);
    localparam logic [CELL_W-1:0]    CELLS_CAP = CELL_W'(64'd1 << ADDRESS_BITS);
    localparam logic [REQ_CNT_W-1:0] REQ_LIMIT = REQ_CNT_W'(MAX_REQUESTS);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic [CELL_W-1:0] seg_start;
        logic [CELL_W-1:0] seg_end;
        logic              is_free;
        logic              used;
        logic [LINK_W-1:0] left;
        logic [LINK_W-1:0] right;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_A_NB,
        ST_A_SPARE,
        ST_RESULT,
        ST_F_H,
        ST_F_S,
        ST_F_CHK,
        ST_F_A,
        ST_F_B,
        ST_F_W1,
        ST_F_W2,
        ST_F_W3,
        ST_F_W4,
        ST_F_DONE
    } t_state;

    typedef enum logic [1:0] {
        MG_NONE,
        MG_RIGHT,
        MG_LEFT,
        MG_BOTH
    } t_merge;

    typedef struct packed {
        logic                 clear;
        logic                 sample;
        logic [SEG_IDX_W-1:0] idx;
    } t_scan_cmd;

    typedef struct packed {
        logic                 found;
        logic [SEG_IDX_W-1:0] idx;
        t_seg                 rec;
        logic [CELL_W-1:0]    len;
        logic                 spare_found;
        logic [SEG_IDX_W-1:0] spare_idx;
    } t_scan_res;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] start_address;
        logic              failed;
    } t_result;

endpackage

// File: sv/worst_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// Worst-fit segment allocator
// Allocates blocks from the largest free segment and frees them with
// coalescing, keeping the segment list and the request handles in memories.
// ----------------------------------------------------------------------------
// An allocate beat runs through the accepting cycle, then the segment memory
// read one entry a cycle to find the largest free segment and a spare slot,
// then a wait for the last read to land, the decision and write-back of the
// granted segment, on a split the write-back of the right neighbour and of
// the spare segment, and the loading of the result. A free beat gives no
// result. After reset and after each write of total_cells, a clearing pass
// rewrites the segment memory; s_axis_tready stays low during it.
module worst_fit_segment_allocator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wfsa_pkg::CELL_W-1:0]       i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // alloc_size [16:0], free_request_number [29:17], zero [31:30]
    input  logic [wfsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // start_address [16:0], zero [23:17]
    output logic [wfsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // failed [0]
    output logic                              m_axis_tuser
);
    import wfsa_pkg::*;

    t_result              w_result;
    t_scan_cmd            w_scan_cmd;
    t_scan_res            w_scan;
    logic                 w_seg_we;
    logic [SEG_IDX_W-1:0] w_seg_waddr;
    t_seg                 w_seg_wdata;
    logic                 w_seg_re;
    logic [SEG_IDX_W-1:0] w_seg_raddr;
    t_seg                 w_seg_rdata;
    logic                 w_hdl_we;
    logic [REQ_IDX_W-1:0] w_hdl_waddr;
    logic [LINK_W-1:0]    w_hdl_wdata;
    logic                 w_hdl_re;
    logic [REQ_IDX_W-1:0] w_hdl_raddr;
    logic [LINK_W-1:0]    w_hdl_rdata;
    logic                 w_out_free;

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_start;
    logic                 r_out_failed;

    assign w_out_free = !r_out_valid || m_axis_tready;

    wfsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_alloc_size (s_axis_tdata[CELL_W-1:0]),
        .i_free_num   (s_axis_tdata[CELL_W+NUM_W-1:CELL_W]),
        .i_out_free   (w_out_free),
        .o_result     (w_result),
        .o_scan_cmd   (w_scan_cmd),
        .i_scan       (w_scan),
        .o_seg_we     (w_seg_we),
        .o_seg_waddr  (w_seg_waddr),
        .o_seg_wdata  (w_seg_wdata),
        .o_seg_re     (w_seg_re),
        .o_seg_raddr  (w_seg_raddr),
        .i_seg_rdata  (w_seg_rdata),
        .o_hdl_we     (w_hdl_we),
        .o_hdl_waddr  (w_hdl_waddr),
        .o_hdl_wdata  (w_hdl_wdata),
        .o_hdl_re     (w_hdl_re),
        .o_hdl_raddr  (w_hdl_raddr),
        .i_hdl_rdata  (w_hdl_rdata)
    );

    wfsa_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_scan_cmd),
        .i_rec   (w_seg_rdata),
        .o_res   (w_scan)
    );

    wfsa_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_seg_we),
        .i_waddr (w_seg_waddr),
        .i_wdata (w_seg_wdata),
        .i_re    (w_seg_re),
        .i_raddr (w_seg_raddr),
        .o_rdata (w_seg_rdata)
    );

    wfsa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_REQUESTS)
    ) u_hdl_ram (
        .i_clk   (i_clk),
        .i_we    (w_hdl_we),
        .i_waddr (w_hdl_waddr),
        .i_wdata (w_hdl_wdata),
        .i_re    (w_hdl_re),
        .i_raddr (w_hdl_raddr),
        .o_rdata (w_hdl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_result.valid) begin
            r_out_start  <= w_result.start_address;
            r_out_failed <= w_result.failed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - CELL_W)'(0), r_out_start};
    assign m_axis_tuser  = r_out_failed;

endmodule

// File: sv/wfsa_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/wfsa_scan.sv
// ----------------------------------------------------------------------------
// Worst-fit scan unit
// Tracks the longest free segment, lowest start on a tie, and the first
// unused slot while the segment table streams past one entry a cycle.
// ----------------------------------------------------------------------------
module wfsa_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wfsa_pkg::t_scan_cmd i_cmd,
    input  wfsa_pkg::t_seg      i_rec,
    output wfsa_pkg::t_scan_res o_res
);
    import wfsa_pkg::*;

    logic                 r_found;
    logic                 r_spare_found;
    logic [SEG_IDX_W-1:0] r_idx;
    logic [SEG_IDX_W-1:0] r_spare_idx;
    t_seg                 r_rec;
    logic [CELL_W-1:0]    r_len;
    logic [CELL_W-1:0]    w_len;
    logic                 w_take;
    logic                 w_spare;

    always_comb begin
        w_len   = i_rec.seg_end - i_rec.seg_start + CELL_W'(1);
        w_take  = i_cmd.sample && i_rec.used && i_rec.is_free &&
                  (!r_found || (w_len > r_len) ||
                   ((w_len == r_len) && (i_rec.seg_start < r_rec.seg_start)));
        w_spare = i_cmd.sample && !i_rec.used && !r_spare_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found       <= 1'b0;
            r_spare_found <= 1'b0;
        end else if (i_cmd.clear) begin
            r_found       <= 1'b0;
            r_spare_found <= 1'b0;
        end else begin
            if (w_take) begin
                r_found <= 1'b1;
            end
            if (w_spare) begin
                r_spare_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec <= i_rec;
            r_len <= w_len;
            r_idx <= i_cmd.idx;
        end
        if (w_spare) begin
            r_spare_idx <= i_cmd.idx;
        end
    end

    always_comb begin
        o_res.found       = r_found;
        o_res.idx         = r_idx;
        o_res.rec         = r_rec;
        o_res.len         = r_len;
        o_res.spare_found = r_spare_found;
        o_res.spare_idx   = r_spare_idx;
    end

endmodule

// File: sv/wfsa_ctrl.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator controller
// Sequences the clearing pass, the table scan, the split on allocate and the
// release with coalescing on free, reading and writing back both memories.
// ----------------------------------------------------------------------------
module wfsa_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wfsa_pkg::CELL_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic [wfsa_pkg::CELL_W-1:0]       i_alloc_size,
    input  logic [wfsa_pkg::NUM_W-1:0]        i_free_num,
    input  logic                              i_out_free,
    output wfsa_pkg::t_result                 o_result,
    output wfsa_pkg::t_scan_cmd               o_scan_cmd,
    input  wfsa_pkg::t_scan_res               i_scan,
    output logic                              o_seg_we,
    output logic [wfsa_pkg::SEG_IDX_W-1:0]    o_seg_waddr,
    output wfsa_pkg::t_seg                    o_seg_wdata,
    output logic                              o_seg_re,
    output logic [wfsa_pkg::SEG_IDX_W-1:0]    o_seg_raddr,
    input  wfsa_pkg::t_seg                    i_seg_rdata,
    output logic                              o_hdl_we,
    output logic [wfsa_pkg::REQ_IDX_W-1:0]    o_hdl_waddr,
    output logic [wfsa_pkg::LINK_W-1:0]       o_hdl_wdata,
    output logic                              o_hdl_re,
    output logic [wfsa_pkg::REQ_IDX_W-1:0]    o_hdl_raddr,
    input  logic [wfsa_pkg::LINK_W-1:0]       i_hdl_rdata
);
    import wfsa_pkg::*;

    t_state               r_state, n_state;
    logic [CELL_W-1:0]    r_total, n_total;
    logic [SEG_IDX_W-1:0] r_clr, n_clr;
    logic [REQ_CNT_W-1:0] r_cnt, n_cnt;
    logic [SEG_IDX_W-1:0] r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic [SEG_IDX_W-1:0] r_pidx, n_pidx;
    logic [CELL_W-1:0]    r_size, n_size;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [LINK_W-1:0]    r_h, n_h;
    t_seg                 r_s, n_s;
    t_seg                 r_a, n_a;
    t_seg                 r_b, n_b;
    logic                 r_a_ok, n_a_ok;
    logic                 r_b_ok, n_b_ok;
    logic [CELL_W-1:0]    r_res_start, n_res_start;
    logic                 r_res_failed, n_res_failed;

    t_seg                 w_rec;
    t_seg                 w_empty;
    t_merge               w_merge;
    logic                 w_af;
    logic                 w_bf;
    logic                 w_ok;
    logic                 w_split;
    logic                 w_cfg;
    logic [NUM_W-1:0]     w_idx;
    t_seg                 w_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_total <= CELLS_CAP;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_pidx       <= n_pidx;
        r_size       <= n_size;
        r_num        <= n_num;
        r_h          <= n_h;
        r_s          <= n_s;
        r_a          <= n_a;
        r_b          <= n_b;
        r_a_ok       <= n_a_ok;
        r_b_ok       <= n_b_ok;
        r_res_start  <= n_res_start;
        r_res_failed <= n_res_failed;
    end

    always_comb begin
        w_af = r_a_ok && r_a.used && r_a.is_free;
        w_bf = r_b_ok && r_b.used && r_b.is_free;
        priority if (w_af && w_bf) begin
            w_merge = MG_BOTH;
        end else if (w_bf) begin
            w_merge = MG_RIGHT;
        end else if (w_af) begin
            w_merge = MG_LEFT;
        end else begin
            w_merge = MG_NONE;
        end
        w_empty = '{seg_start: '0, seg_end: '0, is_free: 1'b0, used: 1'b0,
                    left: SEG_NONE, right: SEG_NONE};
        w_best  = i_scan.rec;
        w_split = i_scan.len > r_size;
        w_ok    = (r_size != '0) && (r_cnt < REQ_LIMIT) && i_scan.found &&
                  (i_scan.len >= r_size) && !(w_split && !i_scan.spare_found);
        w_idx   = r_num - NUM_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_clr        = r_clr;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_pend       = 1'b0;
        n_pidx       = r_pidx;
        n_size       = r_size;
        n_num        = r_num;
        n_h          = r_h;
        n_s          = r_s;
        n_a          = r_a;
        n_b          = r_b;
        n_a_ok       = r_a_ok;
        n_b_ok       = r_b_ok;
        n_res_start  = r_res_start;
        n_res_failed = r_res_failed;
        w_rec        = w_empty;

        o_cfg_ready  = (r_state == ST_IDLE) || (r_state == ST_CLEAR);
        o_in_ready   = (r_state == ST_IDLE) && !i_cfg_valid;
        w_cfg        = i_cfg_valid && o_cfg_ready;
        o_result     = '{valid: 1'b0, start_address: r_res_start, failed: r_res_failed};
        o_scan_cmd   = '{clear: 1'b0, sample: r_pend, idx: r_pidx};
        o_seg_we     = 1'b0;
        o_seg_waddr  = '0;
        o_seg_wdata  = w_empty;
        o_seg_re     = 1'b0;
        o_seg_raddr  = '0;
        o_hdl_we     = 1'b0;
        o_hdl_waddr  = r_cnt[REQ_IDX_W-1:0];
        o_hdl_wdata  = SEG_NONE;
        o_hdl_re     = 1'b0;
        o_hdl_raddr  = w_idx[REQ_IDX_W-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                o_seg_we    = 1'b1;
                o_seg_waddr = r_clr;
                if ((r_clr == '0) && (r_total != '0)) begin
                    w_rec = '{seg_start: CELL_W'(1), seg_end: r_total, is_free: 1'b1,
                              used: 1'b1, left: SEG_NONE, right: SEG_NONE};
                end
                o_seg_wdata = w_rec;
                n_clr       = r_clr + SEG_IDX_W'(1);
                if (r_clr == SEG_IDX_W'(MAX_SEGMENTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_size = i_alloc_size;
                    n_num  = i_free_num;
                    if (i_req_type == REQ_ALLOC) begin
                        o_scan_cmd.clear = 1'b1;
                        n_addr           = '0;
                        n_state          = ST_SCAN;
                    end else begin
                        if (r_cnt < REQ_LIMIT) begin
                            o_hdl_we = 1'b1;
                            n_cnt    = r_cnt + REQ_CNT_W'(1);
                        end
                        if ((i_free_num != '0) && (i_free_num <= r_cnt)) begin
                            n_state = ST_F_H;
                        end
                    end
                end
            end
            ST_SCAN: begin
                o_seg_re    = 1'b1;
                o_seg_raddr = r_addr;
                n_pend      = 1'b1;
                n_pidx      = r_addr;
                n_addr      = r_addr + SEG_IDX_W'(1);
                if (r_addr == SEG_IDX_W'(MAX_SEGMENTS - 1)) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_cnt < REQ_LIMIT) begin
                    o_hdl_we    = 1'b1;
                    o_hdl_wdata = w_ok ? {1'b0, i_scan.idx} : SEG_NONE;
                    n_cnt       = r_cnt + REQ_CNT_W'(1);
                end
                n_res_start  = w_ok ? w_best.seg_start : '0;
                n_res_failed = !w_ok;
                n_state      = ST_RESULT;
                if (w_ok) begin
                    w_rec         = w_best;
                    w_rec.is_free = 1'b0;
                    if (w_split) begin
                        w_rec.seg_end = w_best.seg_start + r_size - CELL_W'(1);
                        w_rec.right   = {1'b0, i_scan.spare_idx};
                        o_seg_re      = w_best.right != SEG_NONE;
                        o_seg_raddr   = w_best.right[SEG_IDX_W-1:0];
                        n_state       = ST_A_NB;
                    end
                    o_seg_we    = 1'b1;
                    o_seg_waddr = i_scan.idx;
                    o_seg_wdata = w_rec;
                end
            end
            ST_A_NB: begin
                w_rec       = i_seg_rdata;
                w_rec.left  = {1'b0, i_scan.spare_idx};
                o_seg_we    = w_best.right != SEG_NONE;
                o_seg_waddr = w_best.right[SEG_IDX_W-1:0];
                o_seg_wdata = w_rec;
                n_state     = ST_A_SPARE;
            end
            ST_A_SPARE: begin
                w_rec = '{seg_start: w_best.seg_start + r_size, seg_end: w_best.seg_end,
                          is_free: 1'b1, used: 1'b1, left: {1'b0, i_scan.idx},
                          right: w_best.right};
                o_seg_we    = 1'b1;
                o_seg_waddr = i_scan.spare_idx;
                o_seg_wdata = w_rec;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                o_result.valid = 1'b1;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_F_H: begin
                o_hdl_re = 1'b1;
                n_state  = ST_F_S;
            end
            ST_F_S: begin
                n_h = i_hdl_rdata;
                if (i_hdl_rdata < SEG_NONE) begin
                    o_seg_re    = 1'b1;
                    o_seg_raddr = i_hdl_rdata[SEG_IDX_W-1:0];
                    n_state     = ST_F_CHK;
                end else begin
                    n_state = ST_F_DONE;
                end
            end
            ST_F_CHK: begin
                n_s = i_seg_rdata;
                if (i_seg_rdata.used && !i_seg_rdata.is_free) begin
                    o_seg_re    = i_seg_rdata.left < SEG_NONE;
                    o_seg_raddr = i_seg_rdata.left[SEG_IDX_W-1:0];
                    n_state     = ST_F_A;
                end else begin
                    n_state = ST_F_DONE;
                end
            end
            ST_F_A: begin
                n_a         = i_seg_rdata;
                n_a_ok      = r_s.left < SEG_NONE;
                o_seg_re    = r_s.right < SEG_NONE;
                o_seg_raddr = r_s.right[SEG_IDX_W-1:0];
                n_state     = ST_F_B;
            end
            ST_F_B: begin
                n_b     = i_seg_rdata;
                n_b_ok  = r_s.right < SEG_NONE;
                n_state = ST_F_W1;
            end
            ST_F_W1: begin
                o_seg_we = 1'b1;
                n_state  = ST_F_W2;
                unique case (w_merge)
                    MG_NONE: begin
                        w_rec         = r_s;
                        w_rec.is_free = 1'b1;
                        o_seg_waddr   = r_h[SEG_IDX_W-1:0];
                        n_state       = ST_F_DONE;
                    end
                    MG_RIGHT: begin
                        w_rec           = r_b;
                        w_rec.seg_start = r_s.seg_start;
                        w_rec.left      = r_s.left;
                        o_seg_waddr     = r_s.right[SEG_IDX_W-1:0];
                    end
                    MG_LEFT: begin
                        w_rec         = r_a;
                        w_rec.seg_end = r_s.seg_end;
                        w_rec.right   = r_s.right;
                        o_seg_waddr   = r_s.left[SEG_IDX_W-1:0];
                    end
                    MG_BOTH: begin
                        w_rec         = r_a;
                        w_rec.seg_end = r_b.seg_end;
                        w_rec.right   = r_b.right;
                        o_seg_waddr   = r_s.left[SEG_IDX_W-1:0];
                        o_seg_re      = r_b.right < SEG_NONE;
                        o_seg_raddr   = r_b.right[SEG_IDX_W-1:0];
                    end
                    default: begin
                        w_rec = r_s;
                    end
                endcase
                o_seg_wdata = w_rec;
            end
            ST_F_W2: begin
                n_state = ST_F_W3;
                unique case (w_merge)
                    MG_RIGHT: begin
                        w_rec       = r_a;
                        w_rec.right = r_s.right;
                        o_seg_we    = r_a_ok;
                        o_seg_waddr = r_s.left[SEG_IDX_W-1:0];
                    end
                    MG_LEFT: begin
                        w_rec       = r_b;
                        w_rec.left  = r_s.left;
                        o_seg_we    = r_b_ok;
                        o_seg_waddr = r_s.right[SEG_IDX_W-1:0];
                    end
                    MG_BOTH: begin
                        w_rec       = i_seg_rdata;
                        w_rec.left  = r_s.left;
                        o_seg_we    = r_b.right < SEG_NONE;
                        o_seg_waddr = r_b.right[SEG_IDX_W-1:0];
                    end
                    default: begin
                        n_state = ST_F_DONE;
                    end
                endcase
                o_seg_wdata = w_rec;
            end
            ST_F_W3: begin
                o_seg_we    = 1'b1;
                o_seg_waddr = r_h[SEG_IDX_W-1:0];
                n_state     = (w_merge == MG_BOTH) ? ST_F_W4 : ST_F_DONE;
            end
            ST_F_W4: begin
                o_seg_we    = 1'b1;
                o_seg_waddr = r_s.right[SEG_IDX_W-1:0];
                n_state     = ST_F_DONE;
            end
            ST_F_DONE: begin
                o_hdl_we    = 1'b1;
                o_hdl_waddr = w_idx[REQ_IDX_W-1:0];
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        if (w_cfg) begin
            n_total = (i_cfg_data > CELLS_CAP) ? CELLS_CAP : i_cfg_data;
            n_cnt   = '0;
            n_clr   = '0;
            n_state = ST_CLEAR;
        end
    end

endmodule

// File: sv/wfsa_checker.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module wfsa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [wfsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tuser
);
    import wfsa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result beat changed while stalled.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CELL_W-1:0] == '0)
        else $error("Failed allocation carries a nonzero start address.");

    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[CELL_W-1:0] != '0)
        else $error("Granted allocation starts at address zero.");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready)
        else $error("Input accepted right after a register write.");

endmodule

bind worst_fit_segment_allocator_top wfsa_checker u_wfsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/worst_fit_segment_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Worst-fit segment allocator testbench
// Drives allocate and free beats under random idling on both streams and
// checks every granted address and failure flag against an in-bench model.
// It also rewrites the cell count between phases.
// ----------------------------------------------------------------------------
module worst_fit_segment_allocator_top_tb;
    import wfsa_pkg::*;

    localparam int NSEG = MAX_SEGMENTS;
    localparam int NREQ = MAX_REQUESTS;

    typedef struct {
        logic              kind;
        logic [CELL_W-1:0] size;
        logic [NUM_W-1:0]  num;
    } t_req;

    typedef struct {
        logic [CELL_W-1:0] start_addr;
        logic              failed;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CELL_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    worst_fit_segment_allocator_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req   pending_reqs[$];
    t_grant expected_grants[$];
    int     errors = 0;
    int     cyc = 0;
    int     beats_in = 0;
    int     hold_cnt = 0;
    bit     hold_done = 0;
    bit     beat_done = 0;

    // Allocator shadow state.
    int cell_count;
    int seg_lo[NSEG];
    int seg_hi[NSEG];
    bit seg_free[NSEG];
    bit seg_used[NSEG];
    int seg_l[NSEG];
    int seg_r[NSEG];
    int handle[NREQ];
    int req_cnt;

    // Stimulus side sequence tracking.
    int gen_seq;
    int gen_allocs[$];

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic alloc_restart(int cells);
        for (int k = 0; k < NSEG; k++) begin
            seg_lo[k] = 0; seg_hi[k] = 0; seg_free[k] = 0; seg_used[k] = 0;
            seg_l[k] = NSEG; seg_r[k] = NSEG;
        end
        for (int k = 0; k < NREQ; k++) handle[k] = NSEG;
        req_cnt = 0;
        cell_count = cells > 65536 ? 65536 : cells;
        if (cell_count > 0) begin
            seg_lo[0] = 1; seg_hi[0] = cell_count; seg_free[0] = 1; seg_used[0] = 1;
        end
    endtask

    function automatic bit free_seg(int s);
        return s < NSEG && seg_used[s] && seg_free[s];
    endfunction

    task automatic drop_seg(int s);
        int a, b;
        a = seg_l[s];
        b = seg_r[s];
        if (a < NSEG) seg_r[a] = b;
        if (b < NSEG) seg_l[b] = a;
        seg_used[s] = 0; seg_free[s] = 0; seg_l[s] = NSEG; seg_r[s] = NSEG;
    endtask

    task automatic note_request(int h);
        if (req_cnt < NREQ) begin
            handle[req_cnt] = h;
            req_cnt++;
        end
    endtask

    task automatic grant_block(int size, output t_grant g);
        int best, spare, best_len, len, nb;
        bit ok;
        best = NSEG; spare = NSEG; best_len = 0;
        ok = size != 0 && req_cnt < NREQ;
        for (int k = 0; k < NSEG; k++) begin
            if (seg_used[k] && seg_free[k]) begin
                len = seg_hi[k] - seg_lo[k] + 1;
                if (best == NSEG || len > best_len ||
                    (len == best_len && seg_lo[k] < seg_lo[best])) begin
                    best = k;
                    best_len = len;
                end
            end else if (!seg_used[k] && spare == NSEG) begin
                spare = k;
            end
        end
        if (best == NSEG || best_len < size) ok = 0;
        if (ok && best_len > size && spare == NSEG) ok = 0;
        if (!ok) begin
            note_request(NSEG);
            g.start_addr = '0;
            g.failed = 1'b1;
            return;
        end
        if (best_len > size) begin
            nb = seg_r[best];
            seg_lo[spare] = seg_lo[best] + size;
            seg_hi[spare] = seg_hi[best];
            seg_free[spare] = 1; seg_used[spare] = 1;
            seg_l[spare] = best; seg_r[spare] = nb;
            if (nb < NSEG) seg_l[nb] = spare;
            seg_r[best] = spare;
            seg_hi[best] = seg_lo[best] + size - 1;
        end
        seg_free[best] = 0;
        note_request(best);
        g.start_addr = CELL_W'(seg_lo[best]);
        g.failed = 1'b0;
    endtask

    task automatic release_request(int num);
        int h, a, b;
        bit af, bf;
        if (num >= 1 && num <= req_cnt) begin
            h = handle[num-1];
            if (h < NSEG && seg_used[h] && !seg_free[h]) begin
                a = seg_l[h];
                b = seg_r[h];
                af = free_seg(a);
                bf = free_seg(b);
                if (!af && !bf) begin
                    seg_free[h] = 1;
                end else if (!af) begin
                    seg_lo[b] = seg_lo[h];
                    drop_seg(h);
                end else if (!bf) begin
                    seg_hi[a] = seg_hi[h];
                    drop_seg(h);
                end else begin
                    seg_hi[a] = seg_hi[b];
                    drop_seg(b);
                    drop_seg(h);
                end
            end
            handle[num-1] = NSEG;
        end
        note_request(NSEG);
    endtask

    // Monitor: predicts on accepted input beats, checks output beats.
    always @(posedge i_clk) begin
        t_grant g, w;
        cyc <= cyc + 1;
        beat_done <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) alloc_restart(int'(i_cfg_data));
            if (s_axis_tvalid && s_axis_tready) begin
                beats_in <= beats_in + 1;
                if (s_axis_tuser == REQ_ALLOC) begin
                    grant_block(int'(s_axis_tdata[CELL_W-1:0]), g);
                    expected_grants.push_back(g);
                end else begin
                    release_request(int'(s_axis_tdata[CELL_W+NUM_W-1:CELL_W]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_grants.size() == 0) begin
                    report("unexpected result beat", int'(m_axis_tdata), -1);
                end else begin
                    w = expected_grants.pop_front();
                    if (m_axis_tdata[CELL_W-1:0] !== w.start_addr)
                        report("start_address", int'(m_axis_tdata[CELL_W-1:0]),
                               int'(w.start_addr));
                    if (m_axis_tuser !== w.failed)
                        report("failed", int'(m_axis_tuser), int'(w.failed));
                end
            end
        end
    end

    function automatic bit quiet_window();
        return (cyc % 20000) < 4000;
    endfunction

    // Driver for the request stream.
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && (!s_axis_tvalid || beat_done)) begin
            if (pending_reqs.size() != 0 && (quiet_window() || $urandom_range(99) >= 22)) begin
                r = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= r.kind;
                s_axis_tdata <= {2'b00, r.num, r.size};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block backs up into its input.
    always @(negedge i_clk) begin
        if (!hold_done && beats_in >= 150) begin
            hold_cnt <= 9000;
            hold_done <= 1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cnt > 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= quiet_window() || $urandom_range(99) >= 22;
    end

    task automatic push_alloc(int size);
        pending_reqs.push_back('{REQ_ALLOC, CELL_W'(size), NUM_W'($urandom)});
        gen_seq++;
        gen_allocs.push_back(gen_seq);
    endtask

    task automatic push_free(int num);
        pending_reqs.push_back('{REQ_FREE, CELL_W'($urandom), NUM_W'(num)});
        gen_seq++;
    endtask

    task automatic random_traffic(int n, int cells);
        int p, sz;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 55) begin
                p = $urandom_range(99);
                if (p < 50) sz = $urandom_range(1, 64);
                else if (p < 80) sz = $urandom_range(1, cells > 1 ? cells / 4 + 1 : 2);
                else if (p < 90) sz = $urandom_range(1, cells > 0 ? cells : 1);
                else sz = $urandom_range(0, 131071);
                push_alloc(sz);
            end else begin
                p = $urandom_range(99);
                if (p < 70 && gen_allocs.size() != 0)
                    push_free(gen_allocs[$urandom_range(gen_allocs.size() - 1)]);
                else if (p < 80) push_free($urandom_range(1, gen_seq + 1));
                else if (p < 88) push_free(0);
                else push_free($urandom_range(0, 8191));
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_grants.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cells(int value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CELL_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_seq = 0;
        gen_allocs.delete();
    endtask

    initial begin
        int a1, a2, a3;
        alloc_restart(65536);
        gen_seq = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_alloc(0);
        push_alloc(65536);
        push_alloc(1);
        push_free(1);
        push_free(2);
        push_free(2);
        push_free(0);
        push_free(8191);
        push_free(4);
        push_alloc(131071);
        push_alloc(100); a1 = gen_seq;
        push_alloc(200); a2 = gen_seq;
        push_alloc(300); a3 = gen_seq;
        push_alloc(50);
        push_free(a2);
        push_free(a1);
        push_free(a3);
        push_alloc(65536);
        push_alloc(65535);
        random_traffic(260, 65536);

        write_cells(1);
        push_alloc(1);
        push_alloc(1);
        push_free(1);
        push_alloc(2);
        push_alloc(1);
        random_traffic(30, 1);

        write_cells(0);
        push_alloc(1);
        push_free(1);
        random_traffic(10, 1);

        // An oversized count saturates to the full address range.
        write_cells(131071);
        push_alloc(65536);
        push_alloc(1);
        push_free(1);

        write_cells(1000);
        random_traffic(240, 1000);

        write_cells(65536);
        random_traffic(30, 65536);

        wait_idle();
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
sv/wfsa_pkg.sv
sv/wfsa_ram.sv
sv/wfsa_scan.sv
sv/wfsa_ctrl.sv
sv/worst_fit_segment_allocator_top.sv
sv/wfsa_checker.sv
tb/worst_fit_segment_allocator_top_tb.sv
